FILE: sv/pms_pkg.sv
// shared types, widths, limits and register codes of the partition move scorer
`timescale 1ns / 1ps

package pms_pkg;

	localparam int CAMERAS_DEF     = 1024;
	localparam int CLUSTERS_DEF    = 16;
	localparam int DEGREE_BITS_DEF = 16;

	localparam int CAM_W      = 10;
	localparam int SRC_W      = 5;
	localparam int TGT_W      = 4;
	localparam int WEIGHT_W   = 11;
	localparam int WC_W       = 15;
	localparam int WD_W       = 31;
	localparam int IMB_W      = 53;
	localparam int CC_W       = 14;
	localparam int RES_W      = 24;
	localparam int LIMIT_W    = 16;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [WC_W-1:0]    CNT_MAX   = {WC_W{1'b1}};
	localparam logic [WD_W-1:0]    DIST_MAX  = {WD_W{1'b1}};
	localparam logic [IMB_W-1:0]   IMB_MAX   = {IMB_W{1'b1}};
	localparam logic [CC_W-1:0]    COPY_MAX  = {CC_W{1'b1}};
	localparam logic [RES_W-1:0]   RES_MAX   = {RES_W{1'b1}};
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2;

	typedef logic [APB_ADDR_W-3:0] reg_idx_t;
	localparam reg_idx_t REG_WEAK_LIMIT = 1'b0;

	// classified item as it travels from front to back
	typedef struct packed {
		logic                mode;
		logic [CAM_W-1:0]    cam;
		logic [TGT_W-1:0]    src;
		logic [TGT_W-1:0]    tgt;
		logic [WEIGHT_W-1:0] weight;
		logic                last;
		logic                src_ok;
		logic                move;
		logic                cam_ok;
	} pms_item_t;

	typedef struct packed {
		logic [WC_W-1:0]  wc;
		logic [WD_W-1:0]  wd;
		logic [IMB_W-1:0] imb;
		logic [CC_W-1:0]  cc;
	} obj_t;

endpackage

FILE: sv/pms_cfg.sv
// register port holding the weak degree limit
`timescale 1ns / 1ps

module pms_cfg import pms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [LIMIT_W-1:0]    weak_limit
);

	logic [LIMIT_W-1:0] limit_q;
	reg_idx_t           reg_idx;
	logic               wr_en;

	assign pready     = 1'b1;
	assign reg_idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en      = psel && penable && pwrite && pready;
	assign weak_limit = limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (wr_en && reg_idx == REG_WEAK_LIMIT) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WEAK_LIMIT: prdata = APB_DATA_W'(limit_q);
			default:        prdata = '0;
		endcase
	end

endmodule

FILE: sv/pms_front.sv
// input stage: accepts items, classifies the move and hands it to the queue
`timescale 1ns / 1ps

module pms_front import pms_pkg::*; #(
	parameter int CAMERAS  = CAMERAS_DEF,
	parameter int CLUSTERS = CLUSTERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                mode,
	input  logic [CAM_W-1:0]    camera,
	input  logic signed [SRC_W-1:0] src_cluster,
	input  logic [TGT_W-1:0]    dst_cluster,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic                last,
	input  logic                hold,
	input  logic                q_full,
	output logic                q_push,
	output pms_item_t           q_data
);

	pms_item_t cls;
	pms_item_t item_s1;
	logic      v_s1;
	logic      accept;

	always_comb begin
		cls.mode   = mode;
		cls.cam    = camera;
		cls.src    = src_cluster[SRC_W-2:0];
		cls.tgt    = dst_cluster;
		cls.weight = weight;
		cls.last   = last;
		// a negative or too large source means unassigned
		cls.src_ok = !src_cluster[SRC_W-1] && (32'(src_cluster[SRC_W-2:0]) < CLUSTERS);
		cls.move   = (32'(dst_cluster) < CLUSTERS) &&
		             !(cls.src_ok && src_cluster[SRC_W-2:0] == dst_cluster);
		cls.cam_ok = 32'(camera) < CAMERAS;
	end

	assign item_stall = hold || (v_s1 && q_full);
	assign accept     = item_valid && !item_stall;
	assign q_push     = v_s1 && !q_full;
	assign q_data     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cls;
		end
	end

endmodule

FILE: sv/pms_fifo.sv
// short queue of classified items between front and back
`timescale 1ns / 1ps

module pms_fifo import pms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pms_item_t wdata,
	input  logic      pop,
	output pms_item_t rdata,
	output logic      full,
	output logic      empty
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	pms_item_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = count_q == NW'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: sv/pms_back.sv
// sequencer that scores and applies moves against the degree, spread and residual memories
`timescale 1ns / 1ps

module pms_back import pms_pkg::*; #(
	parameter int CAMERAS     = CAMERAS_DEF,
	parameter int CLUSTERS    = CLUSTERS_DEF,
	parameter int DEGREE_BITS = DEGREE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LIMIT_W-1:0] weak_limit,
	input  logic               q_empty,
	input  pms_item_t          q_head,
	output logic               q_pop,
	output logic               clearing,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [WC_W-1:0]    weak_count,
	output logic [WD_W-1:0]    weak_distance,
	output logic [IMB_W-1:0]   imbalance,
	output logic [CC_W-1:0]    copied_count,
	output logic               is_better
);

	localparam int DEPTH  = CAMERAS * CLUSTERS;
	localparam int DAW    = $clog2(DEPTH);
	localparam int CAW    = $clog2(CAMERAS);
	localparam int CLW    = $clog2(CLUSTERS);
	localparam int SPW    = $clog2(CLUSTERS + 1);
	localparam int AW     = SPW + 2;
	localparam int CW     = (DEGREE_BITS > LIMIT_W) ? DEGREE_BITS : LIMIT_W;
	localparam int KW     = WEIGHT_W;
	localparam int SW     = RES_W + 1;
	localparam int PROD_W = KW + SW;
	localparam int ISW    = IMB_W + 2;
	localparam int CSW    = CC_W + 2;
	localparam logic [DEGREE_BITS-1:0] DEG_MAX = {DEGREE_BITS{1'b1}};
	localparam logic [DAW-1:0] CLR_LAST = DAW'(DEPTH - 1);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE,
		ST_SRC_RD, ST_SRC_UPD, ST_SRC_ADD,
		ST_TGT_RD, ST_TGT_UPD, ST_TGT_ADD,
		ST_COPY, ST_RES_RD, ST_RES_SRC, ST_RES_TGT, ST_IMB, ST_EMIT
	} state_t;

	// memories
	logic [DEGREE_BITS-1:0] deg_mem [DEPTH];
	logic [SPW-1:0]         spr_mem [CAMERAS];
	logic [RES_W-1:0]       res_mem [CLUSTERS];

	logic [DEGREE_BITS-1:0] deg_rd_q;
	logic [SPW-1:0]         spr_rd_q;
	logic [RES_W-1:0]       res_rd_q;

	logic                   deg_we;
	logic [DAW-1:0]         deg_waddr;
	logic [DAW-1:0]         deg_raddr;
	logic [DEGREE_BITS-1:0] deg_wdata;
	logic                   spr_we;
	logic [CAW-1:0]         spr_waddr;
	logic [SPW-1:0]         spr_wdata;
	logic                   res_we;
	logic [CLW-1:0]         res_waddr;
	logic [CLW-1:0]         res_raddr;
	logic [RES_W-1:0]       res_wdata;

	// sequencer state
	state_t              state_q;
	logic [DAW-1:0]      clr_q;
	pms_item_t           it_q;
	logic [DAW-1:0]      base_q;
	logic                run_open_q;
	obj_t                cand_q;
	obj_t                cur_q;
	logic signed [1:0]   adj_q;
	logic [DEGREE_BITS-1:0] dnew_q;
	logic [PROD_W-1:0]   prod_s_q;
	logic [PROD_W-1:0]   prod_t_q;
	logic                result_valid_q;
	obj_t                out_q;
	logic                better_q;

	logic [DAW-1:0]      addr_src;
	logic [DAW-1:0]      addr_tgt;
	logic [CAW-1:0]      cam_idx;
	logic [CLW-1:0]      src_idx;
	logic [CLW-1:0]      tgt_idx;
	logic                out_free;

	// weak pairing unit
	logic                   upd_state;
	logic [DEGREE_BITS-1:0] wx;
	logic                   is_weak;
	logic [LIMIT_W-1:0]     wx16;
	logic [LIMIT_W-1:0]     wrest;
	logic [LIMIT_W-1:0]     wdist;
	logic [WD_W:0]          dsum;
	logic [WC_W-1:0]        wc_nx;
	logic [WD_W-1:0]        wd_nx;
	logic [DEGREE_BITS-1:0] nd_dn;
	logic [DEGREE_BITS-1:0] nd_up;

	// spread and copies
	logic signed [AW-1:0]   after_raw;
	logic [SPW-1:0]         after_cl;
	logic [SPW-1:0]         ca;
	logic [SPW-1:0]         cb;
	logic signed [SPW:0]    copy_delta;
	logic signed [CSW-1:0]  copy_sum;
	logic [CC_W-1:0]        cc_nx;

	// residuals
	logic [RES_W-1:0]       wres;
	logic [RES_W-1:0]       new_src;
	logic [SW-1:0]          tsum;
	logic [RES_W-1:0]       new_tgt;
	logic [KW-1:0]          k_src;
	logic [KW-1:0]          k_tgt;
	logic [SW-1:0]          s_src;
	logic [SW-1:0]          s_tgt;
	logic [PROD_W-1:0]      prod_s_nx;
	logic [PROD_W-1:0]      prod_t_nx;
	logic signed [ISW-1:0]  imb_sum;
	logic [IMB_W-1:0]       imb_nx;
	logic                   beats;

	function automatic state_t tail_next(input pms_item_t it);
		if (!it.last) begin
			return ST_IDLE;
		end else if (it.move) begin
			return ST_RES_RD;
		end else begin
			return ST_EMIT;
		end
	endfunction

	function automatic state_t head_next(input pms_item_t it);
		if (it.move && it.cam_ok) begin
			return it.src_ok ? ST_SRC_RD : ST_TGT_RD;
		end else begin
			return tail_next(it);
		end
	endfunction

	assign cam_idx  = CAW'(it_q.cam);
	assign src_idx  = CLW'(it_q.src);
	assign tgt_idx  = CLW'(it_q.tgt);
	assign addr_src = base_q + DAW'(it_q.src);
	assign addr_tgt = base_q + DAW'(it_q.tgt);
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign clearing = state_q == ST_CLEAR;
	assign out_free = !result_valid_q || !result_stall;

	// degree table access
	assign deg_raddr = (state_q == ST_SRC_RD) ? addr_src : addr_tgt;

	always_comb begin
		deg_we    = 1'b0;
		deg_waddr = addr_tgt;
		deg_wdata = nd_up;
		case (state_q)
			ST_CLEAR: begin
				deg_we    = 1'b1;
				deg_waddr = clr_q;
				deg_wdata = '0;
			end
			ST_SRC_UPD: begin
				deg_we    = it_q.mode;
				deg_waddr = addr_src;
				deg_wdata = nd_dn;
			end
			ST_TGT_UPD: begin
				deg_we    = it_q.mode;
			end
			default: deg_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_waddr] <= deg_wdata;
		end
		deg_rd_q <= deg_mem[deg_raddr];
	end

	// camera spread access
	always_comb begin
		if (state_q == ST_CLEAR) begin
			spr_we    = 32'(clr_q) < CAMERAS;
			spr_waddr = CAW'(clr_q);
			spr_wdata = '0;
		end else begin
			spr_we    = (state_q == ST_COPY) && it_q.mode;
			spr_waddr = cam_idx;
			spr_wdata = after_cl;
		end
	end

	always_ff @(posedge clk) begin
		if (spr_we) begin
			spr_mem[spr_waddr] <= spr_wdata;
		end
		spr_rd_q <= spr_mem[cam_idx];
	end

	// cluster residual access
	assign res_raddr = (state_q == ST_RES_SRC) ? tgt_idx : src_idx;

	always_comb begin
		res_we    = 1'b0;
		res_waddr = tgt_idx;
		res_wdata = new_tgt;
		case (state_q)
			ST_CLEAR: begin
				res_we    = 32'(clr_q) < CLUSTERS;
				res_waddr = CLW'(clr_q);
				res_wdata = '0;
			end
			ST_RES_SRC: begin
				res_we    = it_q.mode && it_q.src_ok;
				res_waddr = src_idx;
				res_wdata = new_src;
			end
			ST_RES_TGT: begin
				res_we    = it_q.mode;
			end
			default: res_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_mem[res_waddr] <= res_wdata;
		end
		res_rd_q <= res_mem[res_raddr];
	end

	// weak pairing step: removes the old degree, then adds the new one
	always_comb begin
		upd_state = (state_q == ST_SRC_UPD) || (state_q == ST_TGT_UPD);
		wx      = upd_state ? deg_rd_q : dnew_q;
		nd_dn   = (deg_rd_q == '0) ? '0 : deg_rd_q - 1'b1;
		nd_up   = (deg_rd_q == DEG_MAX) ? deg_rd_q : deg_rd_q + 1'b1;
		is_weak = (wx != '0) && (CW'(wx) < CW'(weak_limit));
		wx16    = LIMIT_W'(wx);
		wrest   = weak_limit - wx16;
		wdist   = (wx16 < wrest) ? wx16 : wrest;
		dsum    = {1'b0, cand_q.wd} + (WD_W + 1)'(wdist);
		wc_nx   = cand_q.wc;
		wd_nx   = cand_q.wd;
		if (is_weak) begin
			if (upd_state) begin
				wc_nx = (cand_q.wc == '0) ? '0 : cand_q.wc - 1'b1;
				wd_nx = (cand_q.wd < WD_W'(wdist)) ? '0 : cand_q.wd - WD_W'(wdist);
			end else begin
				wc_nx = (cand_q.wc == CNT_MAX) ? CNT_MAX : cand_q.wc + 1'b1;
				wd_nx = (dsum > (WD_W + 1)'(DIST_MAX)) ? DIST_MAX : dsum[WD_W-1:0];
			end
		end
	end

	// spread after the move and the change in extra copies
	always_comb begin
		after_raw = $signed({2'b00, spr_rd_q}) + AW'(adj_q);
		if (after_raw[AW-1]) begin
			after_cl = '0;
		end else if (after_raw[AW-2:0] > (AW - 1)'(CLUSTERS)) begin
			after_cl = SPW'(CLUSTERS);
		end else begin
			after_cl = after_raw[SPW-1:0];
		end
		ca = (after_cl > SPW'(1)) ? after_cl - 1'b1 : '0;
		cb = (spr_rd_q > SPW'(1)) ? spr_rd_q - 1'b1 : '0;
		copy_delta = $signed({1'b0, ca}) - $signed({1'b0, cb});
		copy_sum   = $signed({2'b00, cand_q.cc}) + CSW'(copy_delta);
		if (copy_sum[CSW-1]) begin
			cc_nx = '0;
		end else if (copy_sum[CSW-2:CC_W] != '0) begin
			cc_nx = COPY_MAX;
		end else begin
			cc_nx = copy_sum[CC_W-1:0];
		end
	end

	// residual squares as (new - old) * (new + old)
	always_comb begin
		wres    = RES_W'(it_q.weight);
		new_src = (res_rd_q > wres) ? res_rd_q - wres : '0;
		k_src   = KW'(res_rd_q - new_src);
		s_src   = SW'(res_rd_q) + SW'(new_src);
		prod_s_nx = it_q.src_ok ? PROD_W'(k_src) * PROD_W'(s_src) : '0;
		tsum    = SW'(res_rd_q) + SW'(wres);
		new_tgt = (tsum > SW'(RES_MAX)) ? RES_MAX : tsum[RES_W-1:0];
		k_tgt   = KW'(new_tgt - res_rd_q);
		s_tgt   = SW'(new_tgt) + SW'(res_rd_q);
		prod_t_nx = PROD_W'(k_tgt) * PROD_W'(s_tgt);
		imb_sum = $signed({2'b00, cand_q.imb}) + $signed(ISW'(prod_t_q)) -
		          $signed(ISW'(prod_s_q));
		if (imb_sum[ISW-1]) begin
			imb_nx = '0;
		end else if (imb_sum[ISW-2:IMB_W] != '0) begin
			imb_nx = IMB_MAX;
		end else begin
			imb_nx = imb_sum[IMB_W-1:0];
		end
	end

	// lexicographic compare against the stored objective
	always_comb begin
		if (cand_q.wc != cur_q.wc) begin
			beats = cand_q.wc < cur_q.wc;
		end else if (cand_q.wd != cur_q.wd) begin
			beats = cand_q.wd < cur_q.wd;
		end else if (cand_q.imb != cur_q.imb) begin
			beats = cand_q.imb < cur_q.imb;
		end else if (cand_q.cc != cur_q.cc) begin
			beats = cand_q.cc < cur_q.cc;
		end else begin
			beats = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			it_q           <= '0;
			base_q         <= '0;
			run_open_q     <= 1'b0;
			cand_q         <= '0;
			cur_q          <= '0;
			adj_q          <= '0;
			dnew_q         <= '0;
			prod_s_q       <= '0;
			prod_t_q       <= '0;
			result_valid_q <= 1'b0;
			out_q          <= '0;
			better_q       <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						it_q       <= q_head;
						base_q     <= q_head.cam_ok ? DAW'(32'(q_head.cam) * CLUSTERS) : '0;
						adj_q      <= '0;
						run_open_q <= 1'b1;
						if (!run_open_q) begin
							cand_q <= cur_q;
						end
						state_q <= head_next(q_head);
					end
				end
				ST_SRC_RD: state_q <= ST_SRC_UPD;
				ST_SRC_UPD: begin
					cand_q.wc <= wc_nx;
					cand_q.wd <= wd_nx;
					dnew_q    <= nd_dn;
					if (deg_rd_q != '0 && nd_dn == '0) begin
						adj_q <= adj_q - 2'sd1;
					end
					state_q <= ST_SRC_ADD;
				end
				ST_SRC_ADD: begin
					cand_q.wc <= wc_nx;
					cand_q.wd <= wd_nx;
					state_q   <= ST_TGT_RD;
				end
				ST_TGT_RD: state_q <= ST_TGT_UPD;
				ST_TGT_UPD: begin
					cand_q.wc <= wc_nx;
					cand_q.wd <= wd_nx;
					dnew_q    <= nd_up;
					if (deg_rd_q == '0 && nd_up != '0) begin
						adj_q <= adj_q + 2'sd1;
					end
					state_q <= ST_TGT_ADD;
				end
				ST_TGT_ADD: begin
					cand_q.wc <= wc_nx;
					cand_q.wd <= wd_nx;
					state_q   <= ST_COPY;
				end
				ST_COPY: begin
					cand_q.cc <= cc_nx;
					state_q   <= tail_next(it_q);
				end
				ST_RES_RD: state_q <= ST_RES_SRC;
				ST_RES_SRC: begin
					prod_s_q <= prod_s_nx;
					state_q  <= ST_RES_TGT;
				end
				ST_RES_TGT: begin
					prod_t_q <= prod_t_nx;
					state_q  <= ST_IMB;
				end
				ST_IMB: begin
					cand_q.imb <= imb_nx;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q      <= cand_q;
						better_q   <= beats;
						run_open_q <= 1'b0;
						if (it_q.mode) begin
							cur_q <= cand_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid  = result_valid_q;
	assign weak_count    = out_q.wc;
	assign weak_distance = out_q.wd;
	assign imbalance     = out_q.imb;
	assign copied_count  = out_q.cc;
	assign is_better     = better_q;

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside the emit step");

	a_deg_write_mode: assert property (@(posedge clk) disable iff (!arst_n)
		deg_we |-> (state_q == ST_CLEAR || it_q.mode))
		else $error("degree table written by a score-only item");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CLEAR |=> state_q != ST_CLEAR)
		else $error("clearing pass restarted");

	a_run_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free) |=> (!run_open_q && state_q == ST_IDLE))
		else $error("run still open after its result");

endmodule

FILE: sv/partition_move_scorer.sv
// top level of the partition move scorer
//
//  channel   | handshake                   | payload
//  item in   | item_valid / item_stall     | mode camera src_cluster dst_cluster weight last
//  result    | result_valid / result_stall | weak_count weak_distance imbalance copied_count is_better
//  config    | psel penable pwrite pready  | paddr pwdata prdata
//
// in the back sequencer a non-last item without a degree part needs only the idle step, a last
// item that moves nothing adds the emit step; the degree part reads, updates and adds for the
// source (if assigned) and the target, then updates the copies; a last item that moves then
// updates the residuals and the imbalance and emits the result. every table entry is read and
// rewritten in separate steps. after reset a clearing pass over all CAMERAS*CLUSTERS entries
// (16384 by default) zeroes the tables; items are stalled meanwhile, configuration writes are
// taken. a waiting result does not stop the back part until it has the next result to show.
`timescale 1ns / 1ps

module partition_move_scorer import pms_pkg::*; #(
	parameter int CAMERAS     = CAMERAS_DEF,
	parameter int CLUSTERS    = CLUSTERS_DEF,
	parameter int DEGREE_BITS = DEGREE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic                    mode,
	input  logic [CAM_W-1:0]        camera,
	input  logic signed [SRC_W-1:0] src_cluster,
	input  logic [TGT_W-1:0]        dst_cluster,
	input  logic [WEIGHT_W-1:0]     weight,
	input  logic                    last,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [WC_W-1:0]         weak_count,
	output logic [WD_W-1:0]         weak_distance,
	output logic [IMB_W-1:0]        imbalance,
	output logic [CC_W-1:0]         copied_count,
	output logic                    is_better,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [APB_ADDR_W-1:0]   paddr,
	input  logic [APB_DATA_W-1:0]   pwdata,
	output logic [APB_DATA_W-1:0]   prdata,
	output logic                    pready
);

	logic [LIMIT_W-1:0] weak_limit;
	logic               q_full;
	logic               q_empty;
	logic               q_push;
	logic               q_pop;
	pms_item_t          q_wdata;
	pms_item_t          q_rdata;
	logic               clearing;

	pms_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.weak_limit (weak_limit)
	);

	pms_front #(
		.CAMERAS  (CAMERAS),
		.CLUSTERS (CLUSTERS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.mode        (mode),
		.camera      (camera),
		.src_cluster (src_cluster),
		.dst_cluster (dst_cluster),
		.weight      (weight),
		.last        (last),
		.hold        (clearing),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	pms_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	pms_back #(
		.CAMERAS     (CAMERAS),
		.CLUSTERS    (CLUSTERS),
		.DEGREE_BITS (DEGREE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.weak_limit    (weak_limit),
		.q_empty       (q_empty),
		.q_head        (q_rdata),
		.q_pop         (q_pop),
		.clearing      (clearing),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.weak_count    (weak_count),
		.weak_distance (weak_distance),
		.imbalance     (imbalance),
		.copied_count  (copied_count),
		.is_better     (is_better)
	);

endmodule
